### rtl/core/tsc_pkg.sv
// Token start classifier package: token class and comment mark codes,
// character constants and the byte classification function.
// No dependencies; used by the top level, the checker and the testbench.
package tsc_pkg;

	// Comment nesting counter width
	localparam int unsigned DEPTH_BITS = 8;
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

	// Configuration port
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	// Token class codes
	localparam logic [4:0] TC_NUMBER  = 5'd0;
	localparam logic [4:0] TC_NAME    = 5'd1;
	localparam logic [4:0] TC_HEXLIT  = 5'd2;
	localparam logic [4:0] TC_SIGN    = 5'd3;
	localparam logic [4:0] TC_COMMA   = 5'd4;
	localparam logic [4:0] TC_PERIOD  = 5'd5;
	localparam logic [4:0] TC_OPEN    = 5'd6;
	localparam logic [4:0] TC_CLOSE   = 5'd7;
	localparam logic [4:0] TC_EQUALS  = 5'd8;
	localparam logic [4:0] TC_QUOTE   = 5'd9;
	localparam logic [4:0] TC_SQUOTE  = 5'd10;
	localparam logic [4:0] TC_COLON   = 5'd11;
	localparam logic [4:0] TC_DOLLAR  = 5'd12;
	localparam logic [4:0] TC_MULTOP  = 5'd13;
	localparam logic [4:0] TC_POWER   = 5'd14;
	localparam logic [4:0] TC_RELOP   = 5'd15;
	localparam logic [4:0] TC_OTHER   = 5'd16;
	localparam logic [4:0] TC_ENDFILE = 5'd17;

	// Comment mark codes
	localparam logic [1:0] CM_NONE  = 2'd0;
	localparam logic [1:0] CM_BEGIN = 2'd1;
	localparam logic [1:0] CM_END   = 2'd2;

	// Character constants
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_X_UP   = 8'h58;
	localparam logic [7:0] CH_X_LOW  = 8'h78;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_name_start(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
			|| (c == CH_UNDER);
	endfunction

	// Space, tab, newline, vertical tab, form feed, carriage return
	function automatic logic is_white(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	// Class of the token starting at c, with one byte of lookahead n
	function automatic logic [4:0] classify(input logic [7:0] c, input logic [7:0] n);
		logic [4:0] tc;
		tc = TC_OTHER;
		if (is_digit(c)) begin
			tc = TC_NUMBER;
		end else if (is_name_start(c)) begin
			tc = ((c == CH_X_UP || c == CH_X_LOW) && n == CH_SQUOTE) ? TC_HEXLIT : TC_NAME;
		end else begin
			unique case (c)
				CH_PLUS, CH_MINUS: tc = TC_SIGN;
				CH_COMMA:          tc = TC_COMMA;
				CH_PERIOD:         tc = is_digit(n) ? TC_NUMBER : TC_PERIOD;
				CH_LPAREN:         tc = TC_OPEN;
				CH_RPAREN:         tc = TC_CLOSE;
				CH_EQUAL:          tc = TC_EQUALS;
				CH_DQUOTE:         tc = TC_QUOTE;
				CH_SQUOTE:         tc = TC_SQUOTE;
				CH_COLON:          tc = TC_COLON;
				CH_DOLLAR:         tc = TC_DOLLAR;
				CH_SLASH:          tc = TC_MULTOP;
				CH_STAR:           tc = (n == CH_STAR) ? TC_POWER : TC_MULTOP;
				CH_LT, CH_GT:      tc = TC_RELOP;
				CH_BANG:           tc = (n == CH_EQUAL) ? TC_RELOP : TC_OTHER;
				default:           tc = TC_OTHER;
			endcase
		end
		return tc;
	endfunction

endpackage

### rtl/core/tsc_if.sv
// Valid/ready channel interfaces of the token start classifier:
// the source byte channel and the token result channel.
// Depends on nothing beyond plain logic types.
interface tsc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic [7:0] next_byte;
	logic       end_of_file;

	modport source (output valid, char_byte, next_byte, end_of_file, input ready);
	modport sink (input valid, char_byte, next_byte, end_of_file, output ready);
endinterface

interface tsc_token_if;
	logic       valid;
	logic       ready;
	logic [4:0] token_class;
	logic [1:0] comment_mark;
	logic       unclosed_comment;

	modport source (output valid, token_class, comment_mark, unclosed_comment, input ready);
	modport sink (input valid, token_class, comment_mark, unclosed_comment, output ready);
endinterface

### rtl/core/token_start_classifier_top.sv
// Token start classifier top level: byte register, classification and
// comment tracking, result register and the APB-style register port.
// Depends on tsc_pkg and the channel interfaces in tsc_if.sv.
//
// Usage:
//   item   - sink channel; one source byte, its lookahead byte and an
//            end-of-file flag per transaction.
//   result - source channel; a token class, comment mark and unclosed
//            comment flag. Whitespace, NUL, comment text and consumed
//            delimiter halves produce no transaction.
//   APB    - register 0 at address 0 is pass_comments (bit 0); the user
//            keeps it written only while the block is idle; the block does not enforce it.
// An accepted byte reaches the result channel through the byte register,
//   then the result register.
// Throughput: one transaction per cycle unless the receiver stalls. The
//   comment depth and skip flag are updated as each byte leaves the byte register.
// Reset clears the depth, the skip flag, pass_comments and both valid
//   flags. When the receiver stalls, the result register holds and one more
//   byte waits in the byte register; bytes that produce nothing still drain.
module token_start_classifier_top
	import tsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	tsc_byte_if.sink          item,
	tsc_token_if.source       result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// Configuration and lexer state
	logic                  pass_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic                  skip_q;

	// Byte register
	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic [7:0]            next_s1;
	logic                  eof_s1;

	// Result register
	logic                  valid_s2;
	logic [4:0]            class_s2;
	logic [1:0]            mark_s2;
	logic                  unclosed_s2;

	// Combinational decision for the byte in stage 1
	logic                  emit;
	logic [4:0]            class_d;
	logic [1:0]            mark_d;
	logic                  unclosed_d;
	logic [DEPTH_BITS-1:0] depth_d;
	logic                  skip_d;
	logic                  adv_s1;
	logic                  slot_free;
	logic                  open_seq;
	logic                  close_seq;
	logic                  in_comment;

	// Register port
	logic                  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == 1'b0);
	assign prdata = (paddr[ADDR_W-1] == 1'b0) ? {{(DATA_W-1){1'b0}}, pass_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b0;
		end else if (cfg_wr) begin
			pass_q <= pwdata[0];
		end
	end

	// Classification and state update
	assign open_seq   = (char_s1 == CH_SLASH) && (next_s1 == CH_STAR);
	assign close_seq  = (char_s1 == CH_STAR) && (next_s1 == CH_SLASH);
	assign in_comment = (depth_q != '0);

	always_comb begin
		emit       = 1'b0;
		class_d    = classify(char_s1, next_s1);
		mark_d     = CM_NONE;
		unclosed_d = 1'b0;
		depth_d    = depth_q;
		skip_d     = skip_q;
		priority if (eof_s1) begin
			emit       = 1'b1;
			class_d    = TC_ENDFILE;
			unclosed_d = in_comment;
			depth_d    = '0;
			skip_d     = 1'b0;
		end else if (skip_q) begin
			skip_d = 1'b0;
		end else if (char_s1 == 8'h00 || is_white(char_s1)) begin
			// dropped
		end else if (close_seq && in_comment) begin
			depth_d = depth_q - DEPTH_BITS'(1);
			skip_d  = 1'b1;
		end else if (open_seq) begin
			if (pass_q) begin
				emit    = !in_comment;
				class_d = TC_OTHER;
				mark_d  = CM_BEGIN;
			end else begin
				if (depth_q != DEPTH_MAX) begin
					depth_d = depth_q + DEPTH_BITS'(1);
				end
				skip_d = 1'b1;
			end
		end else if (in_comment) begin
			// comment text
		end else if (close_seq && pass_q) begin
			emit    = 1'b1;
			class_d = TC_OTHER;
			mark_d  = CM_END;
		end else begin
			emit = 1'b1;
		end
	end

	// Flow control
	assign slot_free  = !valid_s2 || result.ready;
	assign adv_s1     = valid_s1 && (!emit || slot_free);
	assign item.ready = !valid_s1 || adv_s1;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			depth_q  <= '0;
			skip_q   <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv_s1) begin
				depth_q <= depth_d;
				skip_q  <= skip_d;
			end
			if (adv_s1 && emit) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			char_s1 <= item.char_byte;
			next_s1 <= item.next_byte;
			eof_s1  <= item.end_of_file;
		end
		if (adv_s1 && emit) begin
			class_s2    <= class_d;
			mark_s2     <= mark_d;
			unclosed_s2 <= unclosed_d;
		end
	end

	assign result.valid            = valid_s2;
	assign result.token_class      = class_s2;
	assign result.comment_mark     = mark_s2;
	assign result.unclosed_comment = unclosed_s2;

endmodule

### test/token_stream_checker.sv
// Token stream checker: watches the byte and token channels and the register port,
// predicts each token transaction and compares it with what the block sends.
// Depends on tsc_pkg and the channel interfaces in tsc_if.sv.
module token_stream_checker
	import tsc_pkg::*;
#(
	parameter logic [ADDR_W-1:0] PASS_ADDR = '0
) (
	input  logic              clk,
	input  logic              arst_n,
	tsc_byte_if               byte_ch,
	tsc_token_if              token_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                mismatch_count,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [4:0] tclass;
		logic [1:0] mark;
		logic       unclosed;
	} token_t;

	// Predicted block state
	logic [DEPTH_BITS-1:0] nest_depth;
	logic                  skip_second;
	logic                  pass_mode;

	token_t expected_tokens[$];

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	// Token class of a byte at depth zero, with one byte of lookahead
	function automatic logic [4:0] class_of(input logic [7:0] c, input logic [7:0] n);
		if (is_dec(c))
			return TC_NUMBER;
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER)
			return ((c == CH_X_LOW || c == CH_X_UP) && n == CH_SQUOTE) ? TC_HEXLIT : TC_NAME;
		case (c)
			CH_PLUS, CH_MINUS: return TC_SIGN;
			CH_COMMA:          return TC_COMMA;
			CH_PERIOD:         return is_dec(n) ? TC_NUMBER : TC_PERIOD;
			CH_LPAREN:         return TC_OPEN;
			CH_RPAREN:         return TC_CLOSE;
			CH_EQUAL:          return TC_EQUALS;
			CH_DQUOTE:         return TC_QUOTE;
			CH_SQUOTE:         return TC_SQUOTE;
			CH_COLON:          return TC_COLON;
			CH_DOLLAR:         return TC_DOLLAR;
			CH_SLASH:          return TC_MULTOP;
			CH_STAR:           return (n == CH_STAR) ? TC_POWER : TC_MULTOP;
			CH_LT, CH_GT:      return TC_RELOP;
			CH_BANG:           return (n == CH_EQUAL) ? TC_RELOP : TC_OTHER;
			default:           return TC_OTHER;
		endcase
	endfunction

	// Advances the predicted state by one byte; returns 1 when a token is due
	function automatic logic predict_token(input logic [7:0] c, input logic [7:0] n,
		input logic eof, output token_t tok);
		tok = '{TC_OTHER, CM_NONE, 1'b0};
		if (eof) begin
			tok.tclass = TC_ENDFILE;
			tok.unclosed = (nest_depth != '0);
			nest_depth = '0;
			skip_second = 1'b0;
			return 1'b1;
		end
		if (skip_second) begin
			skip_second = 1'b0;
			return 1'b0;
		end
		// NUL and whitespace
		if (c == 8'h00 || c == " " || (c >= 8'h09 && c <= 8'h0D))
			return 1'b0;
		// closing delimiter inside a comment, either mode
		if (c == CH_STAR && n == CH_SLASH && nest_depth != '0) begin
			nest_depth = nest_depth - 1'b1;
			skip_second = 1'b1;
			return 1'b0;
		end
		if (c == CH_SLASH && n == CH_STAR) begin
			if (pass_mode) begin
				if (nest_depth != '0)
					return 1'b0;
				tok.mark = CM_BEGIN;
				return 1'b1;
			end
			// depth saturates
			if (nest_depth != DEPTH_MAX)
				nest_depth = nest_depth + 1'b1;
			skip_second = 1'b1;
			return 1'b0;
		end
		if (nest_depth != '0)
			return 1'b0;
		if (c == CH_STAR && n == CH_SLASH && pass_mode) begin
			tok.mark = CM_END;
			return 1'b1;
		end
		tok.tclass = class_of(c, n);
		return 1'b1;
	endfunction

	// Register snoop, prediction on byte acceptance, comparison on token acceptance
	always @(posedge clk or negedge arst_n) begin
		token_t tok;
		token_t want;
		if (!arst_n) begin
			nest_depth = '0;
			skip_second = 1'b0;
			pass_mode = 1'b0;
			expected_tokens.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == PASS_ADDR)
				pass_mode = pwdata[0];
			if (byte_ch.valid && byte_ch.ready) begin
				if (predict_token(byte_ch.char_byte, byte_ch.next_byte, byte_ch.end_of_file, tok))
					expected_tokens.push_back(tok);
			end
			if (token_ch.valid && token_ch.ready) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected token transaction, class %0d mark %0d unclosed %0d",
						$time, token_ch.token_class, token_ch.comment_mark,
						token_ch.unclosed_comment);
					mismatch_count++;
				end else begin
					want = expected_tokens.pop_front();
					if (token_ch.token_class !== want.tclass) begin
						$display("%0t: token_class expected %0d actual %0d",
							$time, want.tclass, token_ch.token_class);
						mismatch_count++;
					end
					if (token_ch.comment_mark !== want.mark) begin
						$display("%0t: comment_mark expected %0d actual %0d",
							$time, want.mark, token_ch.comment_mark);
						mismatch_count++;
					end
					if (token_ch.unclosed_comment !== want.unclosed) begin
						$display("%0t: unclosed_comment expected %0d actual %0d",
							$time, want.unclosed, token_ch.unclosed_comment);
						mismatch_count++;
					end
				end
			end
			outstanding = expected_tokens.size();
		end
	end

endmodule

### test/tb_token_start_classifier_top.sv
// Testbench top for the token start classifier: clock, reset, register writes,
// source byte stimulus and result back-pressure, and the final verdict.
// Depends on tsc_pkg, tsc_if.sv, the block's top level and token_stream_checker.
module tb_token_start_classifier_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tsc_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_PASS_COMMENTS = '0;
	localparam int DRAIN_CYCLES = 6;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int PHASE_ITEMS = 145;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int mismatch_count;
	int outstanding;
	int holds_wanted;
	int holds_done;
	int items_sent;
	bit steady;

	logic [7:0] line_bytes[$];

	tsc_byte_if  byte_ch ();
	tsc_token_if token_ch ();

	token_start_classifier_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (byte_ch),
		.result  (token_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	token_stream_checker #(.PASS_ADDR(ADDR_PASS_COMMENTS)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_ch        (byte_ch),
		.token_ch       (token_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Gap before a transaction: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One byte transaction; returns right after the accepting edge
	task automatic send_byte(input logic [7:0] c, input logic [7:0] n, input logic eof);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.char_byte <= c;
		byte_ch.next_byte <= n;
		byte_ch.end_of_file <= eof;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Stop offering, wait for every expected token, then let the pipeline drain
	task automatic wait_idle();
		byte_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		case ($urandom_range(0, 5))
			0:       return CH_UNDER;
			1:       return CH_X_LOW;
			2, 3:    return 8'($urandom_range(8'h61, 8'h7A));
			default: return 8'($urandom_range(8'h41, 8'h5A));
		endcase
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'($urandom_range(8'h30, 8'h39));
	endfunction

	function automatic logic [7:0] rand_space();
		case ($urandom_range(0, 6))
			0:       return 8'h09;
			1:       return 8'h0A;
			2:       return 8'h0B;
			3:       return 8'h0C;
			4:       return 8'h0D;
			default: return " ";
		endcase
	endfunction

	task automatic push_str(input string s);
		foreach (s[i])
			line_bytes.push_back(s[i]);
	endtask

	// Random words for comment bodies
	task automatic push_words();
		repeat ($urandom_range(0, 4)) begin
			if ($urandom_range(0, 1))
				line_bytes.push_back(rand_letter());
			else
				line_bytes.push_back(rand_space());
			if ($urandom_range(0, 5) == 0)
				line_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Appends one lexical fragment of a source line
	task automatic push_fragment();
		string ops;
		ops = "+-,.()=\"':$/*<>!";
		case ($urandom_range(0, 13))
			0: begin
				line_bytes.push_back(rand_letter());
				repeat ($urandom_range(0, 4))
					line_bytes.push_back($urandom_range(0, 2) ? rand_letter() : rand_digit());
			end
			1: begin
				repeat ($urandom_range(1, 3)) line_bytes.push_back(rand_digit());
				if ($urandom_range(0, 1)) begin
					line_bytes.push_back(CH_PERIOD);
					line_bytes.push_back(rand_digit());
				end
			end
			2: begin
				line_bytes.push_back(CH_PERIOD);
				line_bytes.push_back($urandom_range(0, 2) ? rand_digit() : rand_letter());
			end
			3: begin
				line_bytes.push_back($urandom_range(0, 1) ? CH_X_LOW : CH_X_UP);
				line_bytes.push_back(CH_SQUOTE);
				repeat ($urandom_range(1, 4)) line_bytes.push_back(rand_digit());
				line_bytes.push_back(CH_SQUOTE);
			end
			4, 5: line_bytes.push_back(ops[$urandom_range(0, ops.len() - 1)]);
			6: push_str("**");
			7: push_str($urandom_range(0, 1) ? "!=" : "<=");
			8: begin
				push_str("/*");
				push_words();
				push_str("*/");
			end
			9: begin
				push_str("/*");
				push_words();
				push_str("/*");
				push_words();
				push_str("*/");
				push_words();
				push_str("*/");
			end
			10: push_str("/*");
			11: push_str("*/");
			12: repeat ($urandom_range(1, 3)) line_bytes.push_back(rand_space());
			default: line_bytes.push_back(8'($urandom_range(0, 255)));
		endcase
	endtask

	// Builds a source line and sends it byte by byte with its lookahead
	task automatic send_line();
		logic [7:0] n;
		line_bytes.delete();
		repeat ($urandom_range(3, 12)) begin
			push_fragment();
			if ($urandom_range(0, 1))
				line_bytes.push_back(rand_space());
		end
		for (int i = 0; i < line_bytes.size(); i++) begin
			n = (i + 1 < line_bytes.size()) ? line_bytes[i + 1] : 8'h00;
			send_byte(line_bytes[i], n, 1'b0);
		end
	endtask

	task automatic run_random(input int target);
		int start;
		start = items_sent;
		while (items_sent - start < target) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				// noise: arbitrary bytes and lookahead
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						$urandom_range(0, 7) == 0);
			end else begin
				send_line();
			end
			if ($urandom_range(0, 7) == 0)
				send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
		end
		steady = 1'b0;
	endtask

	// Result side back-pressure
	initial begin
		int r;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (holds_done < holds_wanted) begin
				// long stall so the block fills and stops taking bytes
				token_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else if (r < 55) begin
				token_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else if (r < 65) begin
				token_ch.ready <= 1'b1;
				repeat ($urandom_range(30, 80)) @(posedge clk);
			end else if (r < 95) begin
				token_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				token_ch.ready <= 1'b0;
				repeat ($urandom_range(8, 30)) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.char_byte = 8'h00;
		byte_ch.next_byte = 8'h00;
		byte_ch.end_of_file = 1'b0;
		token_ch.ready = 1'b0;
		holds_wanted = 0;
		holds_done = 0;
		items_sent = 0;
		steady = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, skipping comments
		apb_write(ADDR_PASS_COMMENTS, 32'd0);
		send_byte("0", " ", 1'b0);
		send_byte(CH_PERIOD, "5", 1'b0);
		send_byte(CH_PERIOD, "a", 1'b0);
		send_byte(CH_X_LOW, CH_SQUOTE, 1'b0);
		send_byte(CH_X_UP, "1", 1'b0);
		send_byte(CH_STAR, CH_STAR, 1'b0);
		send_byte(CH_BANG, CH_EQUAL, 1'b0);
		send_byte(CH_BANG, "a", 1'b0);
		send_byte(8'hFF, 8'h00, 1'b0);
		send_byte(8'h00, 8'hFF, 1'b0);
		send_byte(8'h09, " ", 1'b0);
		send_byte(CH_SLASH, CH_STAR, 1'b0);
		send_byte(CH_STAR, "a", 1'b0);
		send_byte("a", CH_STAR, 1'b0);
		send_byte(CH_STAR, CH_SLASH, 1'b0);
		send_byte(CH_SLASH, 8'h00, 1'b0);
		send_byte(CH_SLASH, CH_STAR, 1'b0);
		send_byte(CH_STAR, " ", 1'b0);
		send_byte(8'hFF, 8'hFF, 1'b1);
		// leave a comment open for the pass-comments checks
		send_byte(CH_SLASH, CH_STAR, 1'b0);
		send_byte(CH_STAR, "z", 1'b0);
		wait_idle();

		// Directed, reporting delimiters, starting inside a comment
		apb_write(ADDR_PASS_COMMENTS, 32'd1);
		send_byte(CH_SLASH, CH_STAR, 1'b0);
		send_byte(CH_STAR, CH_SLASH, 1'b0);
		send_byte(CH_SLASH, " ", 1'b0);
		send_byte(CH_SLASH, CH_STAR, 1'b0);
		send_byte(CH_STAR, CH_SLASH, 1'b0);
		send_byte(CH_SLASH, "a", 1'b0);
		send_byte(8'h00, 8'h00, 1'b1);
		wait_idle();

		// Depth saturation: 256 opens hold the depth at its maximum, so the
		// name that follows is still comment text and end of file flags it
		apb_write(ADDR_PASS_COMMENTS, 32'd0);
		steady = 1'b1;
		repeat (256) begin
			send_byte(CH_SLASH, CH_STAR, 1'b0);
			send_byte(CH_STAR, 8'($urandom_range(0, 255)), 1'b0);
		end
		send_byte("a", 8'h00, 1'b0);
		send_byte(8'h00, 8'h00, 1'b1);
		steady = 1'b0;
		wait_idle();

		// Random source text in both modes
		apb_write(ADDR_PASS_COMMENTS, 32'd1);
		holds_wanted = holds_wanted + 1;
		run_random(PHASE_ITEMS);
		wait_idle();
		apb_write(ADDR_PASS_COMMENTS, 32'd0);
		run_random(PHASE_ITEMS);
		wait_idle();
		apb_write(ADDR_PASS_COMMENTS, 32'd1);
		holds_wanted = holds_wanted + 1;
		run_random(PHASE_ITEMS);
		wait_idle();
		apb_write(ADDR_PASS_COMMENTS, 32'd0);
		run_random(PHASE_ITEMS);
		wait_idle();

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/tsc_pkg.sv
rtl/core/tsc_if.sv
rtl/core/token_start_classifier_top.sv
test/token_stream_checker.sv
test/tb_token_start_classifier_top.sv
